>>> hw/rtl/slc_pkg.sv
package slc_pkg;

    localparam int SAMPLE_WIDTH_DEF = 24;
    localparam int DATA_W           = 24;
    localparam int EXT_W            = 33;
    localparam int FRAC_BITS        = 20;
    localparam int CLIP_W           = 23;

    localparam logic [18:0]              SOFTNESS    = 19'd273589;
    localparam logic signed [DATA_W-1:0] LIMIT4      = 24'sd4194304;
    localparam logic signed [EXT_W-1:0]  LIMIT4_EXT  = 33'sd4194304;
    localparam logic [CLIP_W-1:0]        CLIP_RESET  = 23'd1001382;
    localparam logic [CLIP_W-1:0]        CLIP_LIMIT  = 23'd4194304;

    typedef enum logic [1:0] {
        STEP_P_HELD,
        STEP_P_X,
        STEP_N_HELD,
        STEP_N_X
    } t_step;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_DONE
    } t_state;

    typedef struct packed {
        logic  start;
        logic  step_en;
        t_step step;
    } t_lane_ctrl;

endpackage

>>> hw/rtl/slc_lane.sv
module slc_lane import slc_pkg::*; #(
    parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  t_lane_ctrl                     i_ctrl,
    input  logic signed [SAMPLE_WIDTH-1:0] i_sample,
    input  logic signed [DATA_W-1:0]       i_ref,
    output logic signed [DATA_W-1:0]       o_result
);

    logic signed [DATA_W-1:0] r_held;
    logic                     r_opos;
    logic                     r_oneg;
    logic signed [DATA_W-1:0] r_x;
    logic signed [DATA_W-1:0] r_h;

    logic signed [EXT_W-1:0]            w_ext;
    logic signed [DATA_W-1:0]           w_clamped;
    logic signed [DATA_W-1:0]           w_neg_ref;
    logic signed [DATA_W-1:0]           w_a;
    logic signed [DATA_W-1:0]           w_b;
    logic signed [DATA_W:0]             w_diff;
    logic signed [DATA_W+FRAC_BITS:0]   w_prod;
    logic signed [DATA_W-1:0]           w_frac;
    logic signed [DATA_W:0]             w_sum;
    logic signed [DATA_W-1:0]           w_blend;

    assign w_ext = EXT_W'(i_sample);

    always_comb begin
        if (w_ext > LIMIT4_EXT) begin
            w_clamped = LIMIT4;
        end else if (w_ext < -LIMIT4_EXT) begin
            w_clamped = -LIMIT4;
        end else begin
            w_clamped = w_ext[DATA_W-1:0];
        end
    end

    assign w_neg_ref = -i_ref;

    // The blend a*H + b*S equals a*2^20 + (b-a)*S, so one multiplier serves.
    always_comb begin
        w_a = r_h;
        w_b = i_ref;
        case (i_ctrl.step)
            STEP_P_HELD: begin
                if (r_x < r_h) begin
                    w_a = i_ref;
                    w_b = r_x;
                end else begin
                    w_a = r_h;
                    w_b = i_ref;
                end
            end
            STEP_P_X: begin
                w_a = i_ref;
                w_b = r_h;
            end
            STEP_N_HELD: begin
                if (r_x > r_h) begin
                    w_a = w_neg_ref;
                    w_b = r_x;
                end else begin
                    w_a = r_h;
                    w_b = w_neg_ref;
                end
            end
            STEP_N_X: begin
                w_a = w_neg_ref;
                w_b = r_h;
            end
            default: begin
                w_a = r_h;
                w_b = i_ref;
            end
        endcase
    end

    assign w_diff  = (DATA_W+1)'(w_b) - (DATA_W+1)'(w_a);
    assign w_prod  = (DATA_W+FRAC_BITS+1)'(w_diff)
                   * (DATA_W+FRAC_BITS+1)'($signed({1'b0, SOFTNESS}));
    assign w_frac  = w_prod[DATA_W+FRAC_BITS-1:FRAC_BITS];
    assign w_sum   = (DATA_W+1)'(w_a) + (DATA_W+1)'(w_frac);
    assign w_blend = w_sum[DATA_W-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_held <= '0;
            r_opos <= 1'b0;
            r_oneg <= 1'b0;
        end else if (i_ctrl.step_en) begin
            case (i_ctrl.step)
                STEP_P_HELD: r_opos <= (r_x > i_ref);
                STEP_N_HELD: r_oneg <= (r_x < w_neg_ref);
                STEP_N_X: begin
                    r_held <= r_oneg ? w_blend : r_x;
                end
                default: r_held <= r_held;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.start) begin
            r_x <= w_clamped;
            r_h <= r_held;
        end else if (i_ctrl.step_en) begin
            case (i_ctrl.step)
                STEP_P_HELD: begin
                    if (r_opos) begin
                        r_h <= w_blend;
                    end
                end
                STEP_P_X: begin
                    if (r_opos) begin
                        r_x <= w_blend;
                    end
                end
                STEP_N_HELD: begin
                    if (r_oneg) begin
                        r_h <= w_blend;
                    end
                end
                default: r_x <= r_x;
            endcase
        end
    end

    assign o_result = r_h;

endmodule

>>> hw/rtl/stereo_lookahead_soft_clipper_unit.sv
// Stereo soft clipper with one frame of look-ahead.
// Input channel: i_in_valid with o_in_stall carries one stereo frame per request
// (i_left_sample, i_right_sample, i_block_end). A request is taken at a rising
// edge where i_in_valid is high and o_in_stall is low.
// Output channel: o_out_valid with i_out_stall carries the previous frame's
// adjusted samples and the block end flag of the request that produced them.
// Configuration: i_cfg_valid with o_cfg_ready writes the clip level; write it
// only while no request is in flight.
// Both channels run identical lanes side by side; each lane performs four
// dependent blend steps through its one multiplier, one step per cycle.
// An accepted request runs through the four lane steps and a done state before
// o_out_valid rises; the next request is taken only once that result is loaded.
// When the receiver stalls, the result waits in the output register and the
// next request is still accepted and processed; it then waits in the lanes.
// Synchronous active-low reset clears the held samples, the over flags, the
// control state and restores the default clip level.
module stereo_lookahead_soft_clipper_unit import slc_pkg::*; #(
    parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    output logic                           o_in_stall,
    input  logic signed [SAMPLE_WIDTH-1:0] i_left_sample,
    input  logic signed [SAMPLE_WIDTH-1:0] i_right_sample,
    input  logic                           i_block_end,
    output logic                           o_out_valid,
    input  logic                           i_out_stall,
    output logic signed [SAMPLE_WIDTH-1:0] o_left_out,
    output logic signed [SAMPLE_WIDTH-1:0] o_right_out,
    output logic                           o_block_end_out,
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [CLIP_W-1:0]              i_clip_level
);

    t_state r_state;
    t_state n_state;
    t_step  r_step;
    t_step  n_step;

    logic [CLIP_W-1:0]              r_clip;
    logic                           r_be;
    logic                           r_out_valid;
    logic signed [SAMPLE_WIDTH-1:0] r_left;
    logic signed [SAMPLE_WIDTH-1:0] r_right;
    logic                           r_out_be;

    logic                     w_in_acc;
    logic                     w_load;
    logic signed [DATA_W-1:0] w_ref;
    logic signed [DATA_W-1:0] w_left;
    logic signed [DATA_W-1:0] w_right;
    t_lane_ctrl               w_ctrl;

    assign w_in_acc    = i_in_valid && !o_in_stall;
    assign o_in_stall  = (r_state != ST_IDLE);
    assign o_cfg_ready = 1'b1;

    assign w_ref = (r_clip > CLIP_LIMIT) ? LIMIT4 : DATA_W'(r_clip);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_step  <= STEP_P_HELD;
        end else begin
            r_state <= n_state;
            r_step  <= n_step;
        end
    end

    always_comb begin
        n_state = r_state;
        n_step  = r_step;
        w_load  = 1'b0;
        case (r_state)
            ST_IDLE: begin
                if (w_in_acc) begin
                    n_state = ST_RUN;
                    n_step  = STEP_P_HELD;
                end
            end
            ST_RUN: begin
                case (r_step)
                    STEP_P_HELD: n_step = STEP_P_X;
                    STEP_P_X:    n_step = STEP_N_HELD;
                    STEP_N_HELD: n_step = STEP_N_X;
                    default: begin
                        n_step  = STEP_P_HELD;
                        n_state = ST_DONE;
                    end
                endcase
            end
            ST_DONE: begin
                if (!r_out_valid || !i_out_stall) begin
                    w_load  = 1'b1;
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    assign w_ctrl.start   = w_in_acc;
    assign w_ctrl.step_en = (r_state == ST_RUN);
    assign w_ctrl.step    = r_step;

    slc_lane #(
        .SAMPLE_WIDTH(SAMPLE_WIDTH)
    ) u_lane_left (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ctrl   (w_ctrl),
        .i_sample (i_left_sample),
        .i_ref    (w_ref),
        .o_result (w_left)
    );

    slc_lane #(
        .SAMPLE_WIDTH(SAMPLE_WIDTH)
    ) u_lane_right (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ctrl   (w_ctrl),
        .i_sample (i_right_sample),
        .i_ref    (w_ref),
        .o_result (w_right)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clip <= CLIP_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_clip <= i_clip_level;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_be <= i_block_end;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_load) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_left   <= SAMPLE_WIDTH'(w_left);
            r_right  <= SAMPLE_WIDTH'(w_right);
            r_out_be <= r_be;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_left_out      = r_left;
    assign o_right_out     = r_right;
    assign o_block_end_out = r_out_be;

    a_start_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_acc |=> (r_state == ST_RUN) && (r_step == STEP_P_HELD))
        else $error("Accepted request did not start the lane sequence.");

    a_load_from_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_state) == ST_DONE)
        else $error("Output became valid without a finished lane sequence.");

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && i_out_stall) |=> $stable(r_left) && $stable(r_right))
        else $error("Stalled result was overwritten.");

    a_result_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DONE) |-> (w_left <= LIMIT4) && (w_left >= -LIMIT4)
            && (w_right <= LIMIT4) && (w_right >= -LIMIT4))
        else $error("Lane result outside of the four-unit range.");

endmodule

>>> test/stereo_lookahead_soft_clipper_unit_tb.sv
module stereo_lookahead_soft_clipper_unit_tb import slc_pkg::*; ();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int     SW           = SAMPLE_WIDTH_DEF;
    localparam longint HARD_W       = 774987;
    localparam longint SOFT_W       = (longint'(1) << FRAC_BITS) - HARD_W;
    localparam int     LIMIT_CYCLES = 600000;
    localparam int     SETTLE       = 12;

    typedef enum int {
        STY_NOISE,
        STY_NEAR,
        STY_WAVE,
        STY_EXTREME
    } t_sample_style;

    typedef struct {
        logic signed [SW-1:0] left;
        logic signed [SW-1:0] right;
        logic                 block_end;
    } t_clip_frame;

    class clipper_scoreboard;
        t_clip_frame expected_q[$];
        logic [CLIP_W-1:0] clip_reg;
        longint held[2];
        bit over_pos[2];
        bit over_neg[2];
        int errors;

        function new();
            clip_reg = CLIP_RESET;
            errors = 0;
            for (int c = 0; c < 2; c++) begin
                held[c] = 0;
                over_pos[c] = 0;
                over_neg[c] = 0;
            end
        endfunction

        function void set_clip(logic [CLIP_W-1:0] v);
            clip_reg = v;
        endfunction

        function longint blend(longint a, longint b);
            return (a * HARD_W + b * SOFT_W) >>> FRAC_BITS;
        endfunction

        function longint clip_channel(int ch, longint x_in, longint lvl);
            longint x;
            longint h;
            x = x_in;
            h = held[ch];
            if (x > longint'(LIMIT4)) x = longint'(LIMIT4);
            if (x < -longint'(LIMIT4)) x = -longint'(LIMIT4);
            if (over_pos[ch]) begin
                if (x < h) h = blend(lvl, x);
                else h = blend(h, lvl);
            end
            over_pos[ch] = (x > lvl);
            if (over_pos[ch]) x = blend(lvl, h);
            if (over_neg[ch]) begin
                if (x > h) h = blend(-lvl, x);
                else h = blend(h, -lvl);
            end
            over_neg[ch] = (x < -lvl);
            if (over_neg[ch]) x = blend(-lvl, h);
            held[ch] = x;
            return h;
        endfunction

        function void note_request(logic signed [SW-1:0] l, logic signed [SW-1:0] r,
                                   logic be);
            t_clip_frame f;
            longint lvl;
            lvl = (clip_reg > CLIP_LIMIT) ? longint'(CLIP_LIMIT) : longint'(clip_reg);
            f.left = SW'(clip_channel(0, longint'(l), lvl));
            f.right = SW'(clip_channel(1, longint'(r), lvl));
            f.block_end = be;
            expected_q.push_back(f);
        endfunction

        function void check_result(logic signed [SW-1:0] l, logic signed [SW-1:0] r,
                                   logic be);
            t_clip_frame f;
            if (expected_q.size() == 0) begin
                $error("Unexpected result: left_out %0d, right_out %0d, block_end_out %0b",
                       l, r, be);
                errors++;
                return;
            end
            f = expected_q.pop_front();
            if (l !== f.left) begin
                $error("left_out mismatch: expected %0d, actual %0d", f.left, l);
                errors++;
            end
            if (r !== f.right) begin
                $error("right_out mismatch: expected %0d, actual %0d", f.right, r);
                errors++;
            end
            if (be !== f.block_end) begin
                $error("block_end_out mismatch: expected %0b, actual %0b", f.block_end, be);
                errors++;
            end
        endfunction
    endclass

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 i_in_valid = 1'b0;
    logic                 o_in_stall;
    logic signed [SW-1:0] i_left_sample = '0;
    logic signed [SW-1:0] i_right_sample = '0;
    logic                 i_block_end = 1'b0;
    logic                 o_out_valid;
    logic                 i_out_stall = 1'b0;
    logic signed [SW-1:0] o_left_out;
    logic signed [SW-1:0] o_right_out;
    logic                 o_block_end_out;
    logic                 i_cfg_valid = 1'b0;
    logic                 o_cfg_ready;
    logic [CLIP_W-1:0]    i_clip_level = '0;

    clipper_scoreboard sb;
    int cycle_count = 0;
    int hold_cycles = 0;
    int stall_pct = 0;
    int pattern_left = 0;
    int walk_pos[2] = '{0, 0};
    int walk_step[2] = '{0, 0};
    int walk_amp = 0;

    stereo_lookahead_soft_clipper_unit i_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_left_sample  (i_left_sample),
        .i_right_sample (i_right_sample),
        .i_block_end    (i_block_end),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_left_out     (o_left_out),
        .o_right_out    (o_right_out),
        .o_block_end_out(o_block_end_out),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_clip_level   (i_clip_level)
    );

    always #6 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= LIMIT_CYCLES) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_out_valid && !i_out_stall) begin
                sb.check_result(o_left_out, o_right_out, o_block_end_out);
            end
            if (i_in_valid && !o_in_stall) begin
                sb.note_request(i_left_sample, i_right_sample, i_block_end);
            end
        end
    end

    // The receiver either honors a long hold-off or stalls at a rate that changes now and then.
    always @(posedge i_clk) begin
        if (hold_cycles > 0) begin
            i_out_stall <= 1'b1;
            hold_cycles--;
        end else begin
            if (pattern_left == 0) begin
                case ($urandom_range(0, 5))
                    0, 1: stall_pct = 0;
                    2: stall_pct = 10;
                    3: stall_pct = 30;
                    4: stall_pct = 60;
                    default: stall_pct = 90;
                endcase
                pattern_left = $urandom_range(20, 150);
            end
            pattern_left--;
            i_out_stall <= (int'($urandom_range(0, 99)) < stall_pct);
        end
    end

    task automatic send_frame(logic signed [SW-1:0] l, logic signed [SW-1:0] r, logic be);
        i_in_valid <= 1'b1;
        i_left_sample <= l;
        i_right_sample <= r;
        i_block_end <= be;
        do @(posedge i_clk); while (o_in_stall);
    endtask

    task automatic idle_cycles(int n);
        if (n > 0) begin
            i_in_valid <= 1'b0;
            repeat (n) @(posedge i_clk);
        end
    endtask

    task automatic drain();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (sb.expected_q.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic write_clip(logic [CLIP_W-1:0] v);
        drain();
        i_cfg_valid <= 1'b1;
        i_clip_level <= v;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        sb.set_clip(v);
        @(posedge i_clk);
    endtask

    function automatic int current_level();
        return (sb.clip_reg > CLIP_LIMIT) ? int'(CLIP_LIMIT) : int'(sb.clip_reg);
    endfunction

    function automatic void start_wave();
        walk_amp = $urandom_range(current_level() / 2, 5242880);
        for (int c = 0; c < 2; c++) begin
            walk_step[c] = $urandom_range(2000, 300000);
            if ($urandom_range(0, 1)) walk_step[c] = -walk_step[c];
        end
    endfunction

    function automatic logic signed [SW-1:0] pick_sample(t_sample_style sty, int ch);
        int lvl;
        int v;
        lvl = current_level();
        case (sty)
            STY_NOISE: v = $urandom();
            STY_NEAR: begin
                v = lvl + int'($urandom_range(0, 8192)) - 4096;
                if ($urandom_range(0, 1)) v = -v;
            end
            STY_WAVE: begin
                walk_pos[ch] += walk_step[ch];
                if (walk_pos[ch] > walk_amp) begin
                    walk_pos[ch] = walk_amp;
                    walk_step[ch] = -walk_step[ch];
                end else if (walk_pos[ch] < -walk_amp) begin
                    walk_pos[ch] = -walk_amp;
                    walk_step[ch] = -walk_step[ch];
                end
                v = walk_pos[ch];
            end
            default: begin
                case ($urandom_range(0, 9))
                    0: v = 8388607;
                    1: v = -8388608;
                    2: v = 4194304;
                    3: v = -4194304;
                    4: v = 4194305;
                    5: v = 0;
                    6: v = lvl;
                    7: v = -lvl;
                    8: v = lvl + 1;
                    default: v = -lvl - 1;
                endcase
            end
        endcase
        return SW'(v);
    endfunction

    task automatic run_random(int n_items);
        int done_cnt;
        int burst;
        int gap;
        int pick;
        t_sample_style sty;
        done_cnt = 0;
        while (done_cnt < n_items) begin
            burst = $urandom_range(1, 24);
            pick = $urandom_range(0, 19);
            sty = (pick < 10) ? STY_WAVE : (pick < 14) ? STY_NEAR :
                  (pick < 17) ? STY_NOISE : STY_EXTREME;
            if (sty == STY_WAVE) start_wave();
            for (int k = 0; k < burst; k++) begin
                send_frame(pick_sample(sty, 0), pick_sample(sty, 1),
                           (k == burst - 1) || ($urandom_range(0, 7) == 0));
                done_cnt++;
            end
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            idle_cycles(gap);
        end
    endtask

    initial begin
        logic [CLIP_W-1:0] levels[9];
        sb = new();
        levels = '{CLIP_RESET, '0, CLIP_LIMIT, '1, 23'd1, 23'd2097152,
                   CLIP_W'($urandom_range(0, 4194304)), CLIP_W'($urandom()),
                   CLIP_W'($urandom_range(0, 1048576))};
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        send_frame(24'sd0, 24'sd0, 1'b0);
        send_frame(24'sh7FFFFF, 24'sh800000, 1'b1);
        send_frame(24'sd4194304, -24'sd4194304, 1'b0);
        send_frame(24'sd1001383, -24'sd1001383, 1'b0);
        send_frame(24'sd1001382, -24'sd1001382, 1'b0);
        send_frame(24'sd2000000, -24'sd2000000, 1'b0);
        send_frame(24'sd3000000, -24'sd3000000, 1'b0);
        send_frame(24'sd500000, -24'sd500000, 1'b1);
        send_frame(24'sd1500000, -24'sd1500000, 1'b0);
        send_frame(24'sd1600000, -24'sd1600000, 1'b0);
        send_frame(24'sd1700000, -24'sd1700000, 1'b0);
        send_frame(24'sd100, -24'sd100, 1'b0);
        send_frame(-24'sd2000000, 24'sd2000000, 1'b0);
        send_frame(24'sd2000000, -24'sd2000000, 1'b0);
        send_frame(24'sh800000, 24'sh7FFFFF, 1'b0);
        send_frame(24'sd4194305, -24'sd4194305, 1'b1);
        send_frame(-24'sd1, 24'sd1, 1'b0);
        write_clip('0);
        send_frame(24'sd1, -24'sd1, 1'b0);
        send_frame(24'sd0, 24'sd0, 1'b0);
        send_frame(-24'sd1, 24'sd1, 1'b1);
        write_clip('1);
        send_frame(24'sh7FFFFF, 24'sh800000, 1'b0);
        send_frame(24'sd4194304, -24'sd4194304, 1'b0);
        send_frame(24'sd0, 24'sd0, 1'b1);
        write_clip(CLIP_LIMIT);
        send_frame(24'sd4194305, -24'sd4194305, 1'b0);
        send_frame(24'sd1, -24'sd1, 1'b1);

        foreach (levels[i]) begin
            write_clip(levels[i]);
            if (i == 2) begin
                drain();
                hold_cycles = 400;
                start_wave();
                for (int k = 0; k < 40; k++) begin
                    send_frame(pick_sample(STY_WAVE, 0), pick_sample(STY_WAVE, 1), 1'b0);
                end
            end
            run_random(200);
        end

        drain();
        repeat (SETTLE) @(posedge i_clk);
        if (sb.errors == 0 && sb.expected_q.size() == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule

>>> filelist.f
hw/rtl/slc_pkg.sv
hw/rtl/slc_lane.sv
hw/rtl/stereo_lookahead_soft_clipper_unit.sv
test/stereo_lookahead_soft_clipper_unit_tb.sv
